@@ rtl/ipsp_pkg.sv @@
package ipsp_pkg;

  localparam int ADDR_BITS = 24;
  localparam int SIZE_BITS = ADDR_BITS + 1;
  localparam int LEN_BITS  = 16;
  localparam int CNT_BITS  = 3;

  localparam logic [ADDR_BITS-1:0] EOF_MARK     = 24'h454F46;
  localparam logic [SIZE_BITS-1:0] CAP_RESET    = 25'd16842750;
  localparam logic [CNT_BITS-1:0]  HDR_LAST     = 3'd4;
  localparam logic [CNT_BITS-1:0]  OFS_LAST     = 3'd2;
  localparam logic [CNT_BITS-1:0]  LEN_LAST     = 3'd1;

  typedef enum logic [7:0] {
    PH_HEADER   = 8'b0000_0001,
    PH_OFFSET   = 8'b0000_0010,
    PH_SIZE     = 8'b0000_0100,
    PH_DATA     = 8'b0000_1000,
    PH_RLE_LEN  = 8'b0001_0000,
    PH_RLE_BYTE = 8'b0010_0000,
    PH_DONE     = 8'b0100_0000,
    PH_STOP     = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_RUNNING  = 3'd0,
    ST_DONE     = 3'd1,
    ST_BAD_HDR  = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_OVER_CAP = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    REG_BASE_SIZE = 1'b0,
    REG_CAPACITY  = 1'b1
  } reg_idx_t;

  // "PATCH"
  function automatic logic [7:0] hdr_char(input logic [CNT_BITS-1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (idx)
      3'd0:    c = 8'h50;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h43;
      3'd4:    c = 8'h48;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/ips_patch_stream_parser.sv @@
// out_* is registered: a result appears in the cycle after the input transaction that causes it.
// Throughput: one patch byte per cycle; each byte is parsed by a single state update
//   between the parser registers and the output register, which stall only on out_tready.
// Reset (rst_n low, synchronous): parse restarts at the header, image size is 0,
//   capacity returns to 16842750 and the output register empties.
// After the EOF marker or any error, further bytes are taken and dropped until reset.
module ips_patch_stream_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: patch_byte[7:0]; in_tlast: stream_end
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tlast,
  // out_tdata: target_address[24:0], byte_value[32:25], run_length[48:33],
  //            image_size[73:49], status[76:74], zero[79:77]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [79:0]                     out_tdata,
  // out_tuser: kind[1:0]
  output logic [1:0]                      out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [0:0]                      cfg_index,
  input  logic [ipsp_pkg::SIZE_BITS-1:0]  cfg_data
);
  import ipsp_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  hdr_bad_r, hdr_bad_nxt;
  logic [ADDR_BITS-1:0]  offset_r, offset_nxt;
  logic [LEN_BITS-1:0]   length_r, length_nxt;
  logic [LEN_BITS-1:0]   left_r, left_nxt;
  logic [SIZE_BITS-1:0]  wr_addr_r, wr_addr_nxt;
  logic [SIZE_BITS-1:0]  size_r, size_nxt;
  logic [SIZE_BITS-1:0]  cap_r;

  logic                  out_valid_r;
  kind_t                 out_kind_r;
  logic [SIZE_BITS-1:0]  out_addr_r;
  logic [7:0]            out_val_r;
  logic [LEN_BITS-1:0]   out_run_r;
  logic [SIZE_BITS-1:0]  out_size_r;
  status_t               out_status_r;

  logic                  acc;
  logic                  have;
  kind_t                 res_kind;
  logic [SIZE_BITS-1:0]  res_addr;
  logic [7:0]            res_val;
  logic [LEN_BITS-1:0]   res_run;
  status_t               res_status;

  logic                  hdr_bad;
  logic [ADDR_BITS-1:0]  ofs_shift;
  logic [LEN_BITS-1:0]   len_shift;
  logic [SIZE_BITS-1:0]  rec_end;
  logic                  finished_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign hdr_bad   = hdr_bad_r || (in_tdata != hdr_char(cnt_r));
  assign ofs_shift = {offset_r[ADDR_BITS-9:0], in_tdata};
  assign len_shift = {length_r[LEN_BITS-9:0], in_tdata};
  assign rec_end   = {1'b0, offset_r} + {{(SIZE_BITS-LEN_BITS){1'b0}}, len_shift};

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    hdr_bad_nxt = hdr_bad_r;
    offset_nxt  = offset_r;
    length_nxt  = length_r;
    left_nxt    = left_r;
    wr_addr_nxt = wr_addr_r;
    size_nxt    = size_r;
    have        = 1'b0;
    res_kind    = KIND_STATUS;
    res_addr    = '0;
    res_val     = '0;
    res_run     = '0;
    res_status  = ST_RUNNING;

    unique case (phase_r)
      PH_HEADER: begin
        if (cnt_r == HDR_LAST) begin
          cnt_nxt = '0;
          if (hdr_bad) begin
            have       = 1'b1;
            res_status = ST_BAD_HDR;
            phase_nxt  = PH_STOP;
          end else begin
            phase_nxt  = PH_OFFSET;
          end
        end else begin
          cnt_nxt     = cnt_r + 3'd1;
          hdr_bad_nxt = hdr_bad;
        end
      end
      PH_OFFSET: begin
        offset_nxt = ofs_shift;
        if (cnt_r == OFS_LAST) begin
          cnt_nxt = '0;
          if (ofs_shift == EOF_MARK) begin
            have       = 1'b1;
            res_status = ST_DONE;
            phase_nxt  = PH_DONE;
          end else begin
            length_nxt = '0;
            phase_nxt  = PH_SIZE;
          end
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      PH_SIZE, PH_RLE_LEN: begin
        length_nxt = len_shift;
        if (cnt_r == LEN_LAST) begin
          cnt_nxt = '0;
          if (phase_r == PH_SIZE && len_shift == '0) begin
            phase_nxt = PH_RLE_LEN;
          end else if (rec_end > cap_r) begin
            have       = 1'b1;
            res_status = ST_OVER_CAP;
            phase_nxt  = PH_STOP;
          end else begin
            if (rec_end > size_r) begin
              size_nxt = rec_end;
            end
            if (phase_r == PH_SIZE) begin
              left_nxt    = len_shift;
              wr_addr_nxt = {1'b0, offset_r};
              phase_nxt   = PH_DATA;
            end else begin
              phase_nxt   = PH_RLE_BYTE;
            end
          end
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      PH_DATA: begin
        have        = 1'b1;
        res_kind    = KIND_WRITE;
        res_addr    = wr_addr_r;
        res_val     = in_tdata;
        res_run     = 16'd1;
        left_nxt    = left_r - 16'd1;
        wr_addr_nxt = wr_addr_r + 25'd1;
        if (left_r == 16'd1) begin
          offset_nxt = '0;
          phase_nxt  = PH_OFFSET;
        end
      end
      PH_RLE_BYTE: begin
        have       = 1'b1;
        res_kind   = KIND_FILL;
        res_addr   = {1'b0, offset_r};
        res_val    = in_tdata;
        res_run    = length_r;
        offset_nxt = '0;
        phase_nxt  = PH_OFFSET;
      end
      PH_DONE, PH_STOP: begin
        have = 1'b0;
      end
      default: begin
        phase_nxt = PH_STOP;
      end
    endcase

    finished_nxt = (phase_nxt == PH_DONE) || (phase_nxt == PH_STOP);
    // stream ended before the parse reached a terminal state
    if (in_tlast && !finished_nxt) begin
      phase_nxt  = PH_STOP;
      res_status = ST_TRUNC;
      have       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      cnt_r     <= '0;
      hdr_bad_r <= 1'b0;
      offset_r  <= '0;
      length_r  <= '0;
      left_r    <= '0;
      wr_addr_r <= '0;
      size_r    <= '0;
      cap_r     <= CAP_RESET;
    end else begin
      if (acc) begin
        phase_r   <= phase_nxt;
        cnt_r     <= cnt_nxt;
        hdr_bad_r <= hdr_bad_nxt;
        offset_r  <= offset_nxt;
        length_r  <= length_nxt;
        left_r    <= left_nxt;
        wr_addr_r <= wr_addr_nxt;
        size_r    <= size_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BASE_SIZE) begin
          size_r <= cfg_data;
        end else begin
          cap_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && have) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && have) begin
      out_kind_r   <= res_kind;
      out_addr_r   <= res_addr;
      out_val_r    <= res_val;
      out_run_r    <= res_run;
      out_size_r   <= size_nxt;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {3'b000, out_status_r, out_size_r, out_run_r, out_val_r, out_addr_r};

`ifndef SYNTHESIS
  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_DONE) || (phase_r == PH_STOP)) && !out_valid_r |=> !out_valid_r)
    else $error("result produced after parse finished");

  a_write_run_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_WRITE) |-> (out_run_r == 16'd1))
    else $error("byte write with run length other than one");

  a_status_only_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_STATUS) |-> (out_status_r != ST_RUNNING))
    else $error("status-only result with running status");

  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (left_r != '0))
    else $error("data phase with no bytes left");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OFFSET) |-> (cnt_r <= OFS_LAST))
    else $error("offset byte counter out of range");
`endif

endmodule

@@ bench/tb.sv @@
import ipsp_pkg::*;

localparam logic [23:0] EOF_TAG = 24'h454F46;
localparam logic [39:0] MAGIC   = "PATCH";

typedef struct packed {
  kind_t       kind;
  logic [24:0] addr;
  logic [7:0]  val;
  logic [15:0] run;
  logic [24:0] size;
  status_t     status;
} patch_cmd_t;

// Tracks the parser state and holds the commands it should emit, oldest first.
class patch_cmd_board;
  phase_t      ph;
  logic [2:0]  cnt;
  bit          mism;
  logic [23:0] ofs;
  logic [15:0] len;
  logic [15:0] left;
  logic [24:0] cur;
  logic [24:0] cap;
  patch_cmd_t  pending_cmds[$];
  int          errors;

  function new();
    ph     = PH_HEADER;
    cnt    = 0;
    mism   = 0;
    ofs    = 0;
    len    = 0;
    left   = 0;
    cur    = 0;
    cap    = CAP_RESET;
    errors = 0;
  endfunction

  function void load_reg(reg_idx_t idx, logic [24:0] v);
    if (idx == REG_BASE_SIZE) begin
      cur = v;
    end else begin
      cap = v;
    end
  endfunction

  function void parse_byte(logic [7:0] b, bit last);
    patch_cmd_t  c;
    bit          have;
    logic [24:0] reach;
    logic [15:0] dlt;
    if (ph == PH_DONE || ph == PH_STOP) return;
    have     = 0;
    c.kind   = KIND_STATUS;
    c.addr   = 0;
    c.val    = 0;
    c.run    = 0;
    c.status = ST_RUNNING;
    case (ph)
      PH_HEADER: begin
        if (b != MAGIC[8*(4-cnt) +: 8]) mism = 1;
        cnt++;
        if (cnt == 5) begin
          cnt = 0;
          if (mism) begin
            have = 1;
            c.status = ST_BAD_HDR;
            ph = PH_STOP;
          end else begin
            ph = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        ofs = {ofs[15:0], b};
        cnt++;
        if (cnt == 3) begin
          cnt = 0;
          if (ofs == EOF_TAG) begin
            have = 1;
            c.status = ST_DONE;
            ph = PH_DONE;
          end else begin
            len = 0;
            ph = PH_SIZE;
          end
        end
      end
      PH_SIZE, PH_RLE_LEN: begin
        len = {len[7:0], b};
        cnt++;
        if (cnt == 2) begin
          cnt = 0;
          reach = {1'b0, ofs} + {9'b0, len};
          if (ph == PH_SIZE && len == 0) begin
            ph = PH_RLE_LEN;
          end else if (reach > cap) begin
            have = 1;
            c.status = ST_OVER_CAP;
            ph = PH_STOP;
          end else begin
            if (reach > cur) cur = reach;
            if (ph == PH_SIZE) begin
              left = len;
              ph = PH_DATA;
            end else begin
              ph = PH_RLE_BYTE;
            end
          end
        end
      end
      PH_DATA: begin
        have = 1;
        dlt = len - left;
        c.kind = KIND_WRITE;
        c.addr = {1'b0, ofs} + {9'b0, dlt};
        c.val = b;
        c.run = 1;
        left = left - 16'd1;
        if (left == 0) begin
          ofs = 0;
          ph = PH_OFFSET;
        end
      end
      default: begin
        have = 1;
        c.kind = KIND_FILL;
        c.addr = {1'b0, ofs};
        c.val = b;
        c.run = len;
        ofs = 0;
        ph = PH_OFFSET;
      end
    endcase
    // stream ended before the parse finished
    if (last && ph != PH_DONE && ph != PH_STOP) begin
      ph = PH_STOP;
      c.status = ST_TRUNC;
      have = 1;
    end
    if (have) begin
      c.size = cur;
      pending_cmds.push_back(c);
    end
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check_cmd(logic [1:0] kind, logic [79:0] d);
    patch_cmd_t e;
    if (pending_cmds.size() == 0) begin
      report($sformatf("unexpected result kind %0d data %h", kind, d));
      return;
    end
    e = pending_cmds.pop_front();
    if (kind !== e.kind)
      report($sformatf("kind %0d, want %s", kind, e.kind.name()));
    if (d[24:0] !== e.addr)
      report($sformatf("target_address %h, want %h", d[24:0], e.addr));
    if (d[32:25] !== e.val)
      report($sformatf("byte_value %h, want %h", d[32:25], e.val));
    if (d[48:33] !== e.run)
      report($sformatf("run_length %0d, want %0d", d[48:33], e.run));
    if (d[73:49] !== e.size)
      report($sformatf("image_size %0d, want %0d", d[73:49], e.size));
    if (d[76:74] !== e.status)
      report($sformatf("status %0d, want %s", d[76:74], e.status.name()));
    if (d[79:77] !== 3'b000)
      report($sformatf("padding bits %b not zero", d[79:77]));
  endtask
endclass

module tb;
  localparam int LIMIT       = 300000;
  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [24:0] cfg_data = '0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [79:0] out_tdata;
  wire  [1:0]  out_tuser;
  wire         cfg_ready;

  patch_cmd_board sb = new();

  bit          tx_steady = 0;
  bit          rx_steady = 0;
  bit          hold_req = 0;
  int          cycle_count = 0;
  int          sent = 0;
  int          cut_left = -1;
  logic [24:0] cap_now = CAP_RESET;

  ips_patch_stream_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_cmd(out_tuser, out_tdata);
  end

  // receiver: random backpressure, a steady stretch, and one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_req = 0;
      end else if (rx_steady) begin
        out_tready = 1'b1;
      end else begin
        out_tready = ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, bit last = 0);
    bit lst;
    lst = last || (cut_left == 0);
    if (cut_left >= 0) cut_left--;
    @(negedge clk);
    if (!tx_steady) begin
      while ($urandom_range(99) < 33) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = lst;
    do begin
      @(posedge clk);
    end while (!in_tready);
    sb.parse_byte(b, lst);
    sent++;
  endtask

  // big-endian multi-byte field
  task automatic send_field(logic [23:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) send_byte(v[8*i +: 8]);
  endtask

  task automatic send_lit(logic [23:0] ofs, int n);
    send_field(ofs, 3);
    send_field(24'(n), 2);
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_fill(logic [23:0] ofs, logic [15:0] run, logic [7:0] v);
    send_field(ofs, 3);
    send_field(24'd0, 2);
    send_field({8'd0, run}, 2);
    send_byte(v);
  endtask

  // stop offering, wait for all outstanding commands, then let the pipe drain
  task automatic settle(int extra);
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [24:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    sb.load_reg(idx, v);
    if (idx == REG_CAPACITY) cap_now = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // offset that keeps offset + len within capacity and never spells the EOF marker
  function automatic logic [23:0] pick_ofs(int unsigned len);
    int unsigned hi;
    int unsigned o;
    int unsigned span;
    hi = cap_now - len;
    if (hi > 24'hFFFFFF) hi = 24'hFFFFFF;
    span = (hi > 255) ? 255 : hi;
    case ($urandom_range(2))
      0:       o = $urandom_range(hi);
      1:       o = $urandom_range(span);
      default: o = hi - $urandom_range(span);
    endcase
    if (o == EOF_TAG) o--;
    return o[23:0];
  endfunction

  task automatic rand_records(int n_bytes);
    int          start;
    int          r;
    int          n;
    int unsigned run;
    start = sent;
    while (sent - start < n_bytes) begin
      r = $urandom_range(9);
      if (r < 6) begin
        n = ($urandom_range(7) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
        if (cap_now < n) send_fill(24'd0, 16'd0, 8'($urandom_range(255)));
        else send_lit(pick_ofs(n), n);
      end else begin
        case (r)
          9:       run = 0;
          8:       run = $urandom_range(16);
          default: run = $urandom_range(65535);
        endcase
        if (run > cap_now) run = $urandom_range(cap_now);
        send_fill(pick_ofs(run), 16'(run), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_reg(REG_BASE_SIZE, 25'd0);
    write_reg(REG_CAPACITY, CAP_RESET);
    for (int i = 4; i >= 0; i--) send_byte(MAGIC[8*i +: 8]);
    // two writes straddling the 24-bit boundary, data extremes
    send_field(24'hFFFFFF, 3);
    send_field(24'd2, 2);
    send_byte(8'h00);
    send_byte(8'hFF);
    // longest fill at the top offset grows the image to full capacity
    send_fill(24'hFFFFFF, 16'hFFFF, 8'hFF);
    // empty fill at an offset one off from the EOF marker
    send_fill(24'h454F47, 16'h0000, 8'hA5);

    settle(4);
    write_reg(REG_BASE_SIZE, 25'h1000000);
    rand_records(130);

    settle(4);
    write_reg(REG_BASE_SIZE, 25'($urandom_range(25'h1000000)));
    write_reg(REG_CAPACITY, 25'($urandom_range(CAP_RESET, 100000)));
    hold_req = 1;
    rand_records(130);

    // zero capacity: only empty fills at offset zero fit
    settle(4);
    write_reg(REG_CAPACITY, 25'd0);
    write_reg(REG_BASE_SIZE, 25'd0);
    rand_records(16);

    settle(4);
    write_reg(REG_CAPACITY, 25'($urandom_range(5000, 1)));
    write_reg(REG_BASE_SIZE, 25'($urandom_range(3000)));
    rand_records(130);

    settle(4);
    write_reg(REG_CAPACITY, CAP_RESET);
    tx_steady = 1;
    rx_steady = 1;
    rand_records(130);
    tx_steady = 0;
    rx_steady = 0;

    settle(4);
    case ($urandom_range(2))
      0: begin
        send_byte(EOF_TAG[23:16]);
        send_byte(EOF_TAG[15:8]);
        send_byte(EOF_TAG[7:0], 1);
      end
      1: begin
        cut_left = $urandom_range(7);
        send_lit(pick_ofs(3), 3);
      end
      default: begin
        write_reg(REG_CAPACITY, 25'($urandom_range(24'hFFFFFF)));
        send_lit(24'hFFFFFF, $urandom_range(4, 1));
      end
    endcase
    // parser has stopped: these bytes must be dropped
    send_byte(8'($urandom_range(255)), 1);
    repeat (6) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));

    settle(20);
    if (sb.pending_cmds.size() != 0)
      sb.report($sformatf("%0d commands never arrived", sb.pending_cmds.size()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

@@ ips_patch_stream_parser.f @@
rtl/ipsp_pkg.sv
rtl/ips_patch_stream_parser.sv
bench/tb.sv
